[rtl/fcr_pkg.sv]
// Shared definitions for the framed command receiver: field widths, phase and class codes,
// the packed result layout and the byte-wide CRC-16 step.
// No dependencies.
package fcr_pkg;

    // Longest body (fields, payload and CRC) that a frame may carry.
    localparam int MAX_BODY = 224;
    localparam int TAKEN_W  = 9;

    // CRC-16 (init all ones, MSB first, no final inversion).
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Phases within the body; during the hunt the same register counts matched header bytes.
    localparam logic [2:0] PH_DIR     = 3'd0;
    localparam logic [2:0] PH_ADDR_LO = 3'd1;
    localparam logic [2:0] PH_ADDR_HI = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CRC_LO  = 3'd5;
    localparam logic [2:0] PH_CRC_HI  = 3'd6;
    localparam logic [2:0] HDR_LEN    = 3'd6;

    localparam logic [7:0] SYNC_A   = 8'h55;
    localparam logic [7:0] SYNC_B   = 8'hAA;
    localparam logic [7:0] SYNC_Z   = 8'h00;
    localparam logic [7:0] DIR_WRITE = 8'h01;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Command classes.
    localparam logic [2:0] CLS_CRC_ERROR = 3'd0;
    localparam logic [2:0] CLS_ENTER     = 3'd1;
    localparam logic [2:0] CLS_ERASE     = 3'd2;
    localparam logic [2:0] CLS_VERIFY    = 3'd3;
    localparam logic [2:0] CLS_PROGRAM   = 3'd4;
    localparam logic [2:0] CLS_BAD       = 3'd5;

    localparam logic [15:0] ADDR_ENTER    = 16'h8000;
    localparam logic [15:0] ADDR_ERASE    = 16'h8001;
    localparam logic [15:0] ADDR_VERIFY   = 16'h8002;
    localparam logic [15:0] ADDR_PROG_LO  = 16'h9001;
    localparam logic [15:0] ADDR_PROG_HI  = 16'h9FFF;

    // Result payload, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]  pad;
        logic [2:0]  command_class;
        logic        crc_ok;
        logic [7:0]  payload_length;
        logic [15:0] target_address;
        logic [7:0]  direction;
        logic [7:0]  data_index;
        logic [7:0]  data_byte;
    } t_out_data;

    // Expected header byte at a given hunt position.
    function automatic logic [7:0] sync_byte(input logic [2:0] pos);
        logic [7:0] v;
        unique case (pos)
            3'd0:    v = SYNC_A;
            3'd1:    v = SYNC_B;
            3'd2:    v = SYNC_Z;
            3'd3:    v = SYNC_Z;
            3'd4:    v = SYNC_B;
            default: v = SYNC_A;
        endcase
        return v;
    endfunction

    // One byte through the CRC, eight bit steps unrolled.
    function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Command class from the target address.
    function automatic logic [2:0] classify(input logic [15:0] a);
        logic [2:0] cls;
        priority if (a == ADDR_ENTER) begin
            cls = CLS_ENTER;
        end else if (a == ADDR_ERASE) begin
            cls = CLS_ERASE;
        end else if (a == ADDR_VERIFY) begin
            cls = CLS_VERIFY;
        end else if (a >= ADDR_PROG_LO && a <= ADDR_PROG_HI) begin
            cls = CLS_PROGRAM;
        end else begin
            cls = CLS_BAD;
        end
        return cls;
    endfunction

endpackage

[rtl/framed_command_receiver_crc16_unit.sv]
// Framed command receiver: header hunt, field capture, payload streaming and CRC-16 check.
// Depends on fcr_pkg.
//
// Usage
//   Received bytes enter on the s_axis channel, one byte per request. Results leave on the
//   m_axis channel: a payload byte request (tuser 0) for every payload byte, and one summary
//   request (tuser 1, tlast 1) after the CRC high byte carrying the fields, the CRC verdict
//   and the command class. Header, field and CRC low bytes give no result.
//   A byte accepted from s_axis sits in the input register; the decode, CRC update and class
//   lookup then settle into the result register that drives m_axis. Throughput is one byte
//   per cycle unless a result must wait on a full result register; the two registers together
//   let a new byte be taken while a result waits to be collected.
//   When the downstream side stalls, a byte that produces a result waits in the input
//   register and s_axis_tready falls; bytes that produce no result still drain.
//   A frame whose body runs past MAX_BODY bytes is dropped without a summary and the byte
//   that overran starts a fresh header hunt.
//   Synchronous active-low reset empties both registers and returns to the header hunt
//   with the CRC preset to all ones.
module framed_command_receiver_crc16_unit
    import fcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_byte, [15:8] data_index, [23:16] direction, [39:24] target_address,
    // [47:40] payload_length, [48] crc_ok, [51:49] command_class, [55:52] zero
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] item_kind
    output logic        m_axis_tlast    // last
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Receiver state
    logic [2:0]  r_hdr_pos, n_hdr_pos;
    logic        r_in_body, n_in_body;
    logic [7:0]  r_body_cnt, n_body_cnt;
    logic [7:0]  r_dir, n_dir;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;

    // Result register
    logic        r_out_valid;
    logic        r_out_kind;
    logic        r_out_last;
    t_out_data   r_out_data;

    logic               w_emit;
    logic               w_kind;
    t_out_data          w_data;
    logic               w_out_free;
    logic               w_advance;
    logic [7:0]         w_eff_len;
    logic [TAKEN_W-1:0] w_taken;
    logic               w_drop;
    logic               w_hunt;
    logic [2:0]         w_hunt_pos;
    logic [15:0]        w_crc_next;
    logic [15:0]        w_rcv_crc;
    logic               w_crc_ok;

    // Handshake: the input register moves on unless its result finds the output full.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && (!w_emit || w_out_free);
    assign s_axis_tready = !r_in_valid || w_advance;

    // Body bookkeeping shared by the decode below.
    assign w_eff_len  = (r_dir == DIR_WRITE) ? r_len : 8'd0;
    assign w_crc_next = crc16_byte(r_crc, r_in_byte);
    assign w_rcv_crc  = {r_in_byte, r_crc_lo};
    assign w_crc_ok   = (w_rcv_crc == r_crc);

    always_comb begin
        if (r_hdr_pos < PH_PAYLOAD) begin
            w_taken = {{(TAKEN_W-3){1'b0}}, r_hdr_pos};
        end else if (r_hdr_pos == PH_PAYLOAD) begin
            w_taken = TAKEN_W'(4) + {1'b0, r_body_cnt};
        end else begin
            w_taken = TAKEN_W'(4) + {1'b0, w_eff_len}
                    + {{(TAKEN_W-1){1'b0}}, (r_hdr_pos == PH_CRC_HI)};
        end
    end

    assign w_drop = r_in_body && ((r_hdr_pos > PH_CRC_HI) || (w_taken >= TAKEN_W'(MAX_BODY)));

    // Decode of one byte: body phases, then the header hunt.
    always_comb begin
        n_hdr_pos  = r_hdr_pos;
        n_in_body  = r_in_body;
        n_body_cnt = r_body_cnt;
        n_dir      = r_dir;
        n_addr     = r_addr;
        n_len      = r_len;
        n_crc      = r_crc;
        n_crc_lo   = r_crc_lo;
        w_emit     = 1'b0;
        w_kind     = KIND_PAYLOAD;
        w_data     = '0;
        w_hunt     = !r_in_body || w_drop;
        w_hunt_pos = (w_drop || r_hdr_pos > 3'd5) ? 3'd0 : r_hdr_pos;

        if (r_in_body && !w_drop) begin
            unique case (r_hdr_pos)
                PH_DIR: begin
                    n_dir     = r_in_byte;
                    n_crc     = w_crc_next;
                    n_hdr_pos = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                    n_addr    = {r_addr[15:8], r_in_byte};
                    n_crc     = w_crc_next;
                    n_hdr_pos = PH_ADDR_HI;
                end
                PH_ADDR_HI: begin
                    n_addr    = {r_in_byte, r_addr[7:0]};
                    n_crc     = w_crc_next;
                    n_hdr_pos = PH_LEN;
                end
                PH_LEN: begin
                    n_len      = r_in_byte;
                    n_crc      = w_crc_next;
                    n_body_cnt = 8'd0;
                    n_hdr_pos  = (r_dir == DIR_WRITE && r_in_byte != 8'd0) ? PH_PAYLOAD
                                                                            : PH_CRC_LO;
                end
                PH_PAYLOAD: begin
                    w_emit                = 1'b1;
                    w_kind                = KIND_PAYLOAD;
                    w_data.data_byte      = r_in_byte;
                    w_data.data_index     = r_body_cnt;
                    w_data.direction      = r_dir;
                    w_data.target_address = r_addr;
                    w_data.payload_length = w_eff_len;
                    n_crc                 = w_crc_next;
                    n_body_cnt            = r_body_cnt + 8'd1;
                    if (r_body_cnt + 8'd1 == w_eff_len) begin
                        n_hdr_pos = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    n_crc_lo  = r_in_byte;
                    n_hdr_pos = PH_CRC_HI;
                end
                default: begin
                    // CRC high byte: close the frame with a summary.
                    w_emit                = 1'b1;
                    w_kind                = KIND_SUMMARY;
                    w_data.direction      = r_dir;
                    w_data.target_address = r_addr;
                    w_data.payload_length = w_eff_len;
                    w_data.crc_ok         = w_crc_ok;
                    w_data.command_class  = w_crc_ok ? classify(r_addr) : CLS_CRC_ERROR;
                    n_in_body             = 1'b0;
                    n_hdr_pos             = 3'd0;
                end
            endcase
        end

        // Header hunt; a mismatching sync-start byte counts as the first header byte.
        if (w_hunt) begin
            n_in_body = 1'b0;
            if (r_in_byte == sync_byte(w_hunt_pos)) begin
                if (w_hunt_pos + 3'd1 == HDR_LEN) begin
                    n_in_body  = 1'b1;
                    n_hdr_pos  = PH_DIR;
                    n_body_cnt = 8'd0;
                    n_crc      = CRC_INIT;
                end else begin
                    n_hdr_pos = w_hunt_pos + 3'd1;
                end
            end else begin
                n_hdr_pos = (r_in_byte == SYNC_A) ? 3'd1 : 3'd0;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Receiver state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos  <= 3'd0;
            r_in_body  <= 1'b0;
            r_body_cnt <= 8'd0;
            r_dir      <= 8'd0;
            r_addr     <= 16'd0;
            r_len      <= 8'd0;
            r_crc      <= CRC_INIT;
            r_crc_lo   <= 8'd0;
        end else if (w_advance) begin
            r_hdr_pos  <= n_hdr_pos;
            r_in_body  <= n_in_body;
            r_body_cnt <= n_body_cnt;
            r_dir      <= n_dir;
            r_addr     <= n_addr;
            r_len      <= n_len;
            r_crc      <= n_crc;
            r_crc_lo   <= n_crc_lo;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out_kind <= w_kind;
            r_out_last <= (w_kind == KIND_SUMMARY);
            r_out_data <= w_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // Checks

    // The input side only stalls behind a full result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("input stalled without a pending result");

    // A produced result always lands in the result register.
    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_emit) |=> r_out_valid)
        else $error("result lost on advance");

    // The payload phase never holds a count at or beyond the effective length.
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_body && r_hdr_pos == PH_PAYLOAD) |-> (r_body_cnt < w_eff_len))
        else $error("payload count beyond length");

    // During the hunt the position always stays below the header length.
    a_hunt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_body |-> (r_hdr_pos < HDR_LEN))
        else $error("hunt position out of range");

    // Payload results carry no verdict and no frame end.
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_PAYLOAD) |->
        (!r_out_last && !r_out_data.crc_ok && r_out_data.command_class == CLS_CRC_ERROR))
        else $error("payload result carries summary fields");

endmodule

[tb/framed_command_receiver_crc16_checker.sv]
// Checker for the framed command receiver: watches both stream channels, predicts results.
// Keeps its own copy of the deframer state and compares every result request field by field.
// Depends on fcr_pkg.
`timescale 1ns / 100ps

module framed_command_receiver_crc16_checker
    import fcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_data,    // [7:0] rx_byte
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    // [7:0] data_byte, [15:8] data_index, [23:16] direction, [39:24] target_address,
    // [47:40] payload_length, [48] crc_ok, [51:49] command_class, [55:52] zero
    input  logic [55:0] i_res_data,
    input  logic        i_res_user,   // [0] item_kind
    input  logic        i_res_last,
    output int          o_fail_count,
    output int          o_pending
);

    // Header bytes in line order, first byte in the top bits.
    localparam logic [47:0] SYNC_WORD = {SYNC_A, SYNC_B, SYNC_Z, SYNC_Z, SYNC_B, SYNC_A};

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic [7:0]  direction;
        logic [15:0] address;
        logic [7:0]  length;
        logic        crc_ok;
        logic [2:0]  cmd_class;
        logic        last;
    } t_frame_item;

    // Results predicted but not yet seen on the output channel.
    t_frame_item frame_items_due[$];
    t_frame_item due_item;
    int          mismatches = 0;

    // Deframer state as the block should hold it.
    logic [2:0]  hunt_pos      = PH_DIR;
    logic        in_body       = 1'b0;
    logic [7:0]  payload_count = 8'd0;
    logic [7:0]  dir_q         = 8'd0;
    logic [15:0] addr_q        = 16'd0;
    logic [7:0]  len_q         = 8'd0;
    logic [15:0] crc_q         = CRC_INIT;
    logic [7:0]  crc_lo_q      = 8'd0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // CRC-16, MSB first, one byte at a time.
    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    // Command class from the address field.
    function automatic logic [2:0] address_class(input logic [15:0] a);
        if (a == ADDR_ENTER) begin
            return CLS_ENTER;
        end else if (a == ADDR_ERASE) begin
            return CLS_ERASE;
        end else if (a == ADDR_VERIFY) begin
            return CLS_VERIFY;
        end else if (a >= ADDR_PROG_LO && a <= ADDR_PROG_HI) begin
            return CLS_PROGRAM;
        end
        return CLS_BAD;
    endfunction

    // Advances the predicted state by one received byte and queues any result it causes.
    task automatic deframe_byte(input logic [7:0] b);
        t_frame_item item;
        int          taken;
        logic [7:0]  eff_len;
        logic [2:0]  phase;
        logic        hunting;
        phase   = hunt_pos;
        hunting = 1'b1;
        eff_len = (dir_q == DIR_WRITE) ? len_q : 8'd0;
        item    = '0;
        if (in_body) begin
            // Body bytes already taken, counting fields, payload and CRC.
            if (phase < PH_PAYLOAD) begin
                taken = phase;
            end else if (phase == PH_PAYLOAD) begin
                taken = 4 + payload_count;
            end else begin
                taken = 4 + eff_len + (phase - PH_CRC_LO);
            end
            if (phase > PH_CRC_HI || taken >= MAX_BODY) begin
                // Overlong body: drop the frame and hunt with this byte.
                in_body  = 1'b0;
                hunt_pos = PH_DIR;
                phase    = PH_DIR;
            end else begin
                hunting = 1'b0;
                case (phase)
                    PH_DIR: begin
                        dir_q    = b;
                        crc_q    = crc_fold(crc_q, b);
                        hunt_pos = PH_ADDR_LO;
                    end
                    PH_ADDR_LO: begin
                        addr_q[7:0] = b;
                        crc_q       = crc_fold(crc_q, b);
                        hunt_pos    = PH_ADDR_HI;
                    end
                    PH_ADDR_HI: begin
                        addr_q[15:8] = b;
                        crc_q        = crc_fold(crc_q, b);
                        hunt_pos     = PH_LEN;
                    end
                    PH_LEN: begin
                        len_q         = b;
                        crc_q         = crc_fold(crc_q, b);
                        payload_count = 8'd0;
                        hunt_pos = (dir_q == DIR_WRITE && b != 8'd0) ? PH_PAYLOAD : PH_CRC_LO;
                    end
                    PH_PAYLOAD: begin
                        item.kind       = KIND_PAYLOAD;
                        item.data_byte  = b;
                        item.data_index = payload_count;
                        item.direction  = dir_q;
                        item.address    = addr_q;
                        item.length     = eff_len;
                        item.cmd_class  = CLS_CRC_ERROR;
                        frame_items_due.push_back(item);
                        crc_q         = crc_fold(crc_q, b);
                        payload_count = payload_count + 8'd1;
                        if (payload_count == eff_len) begin
                            hunt_pos = PH_CRC_LO;
                        end
                    end
                    PH_CRC_LO: begin
                        crc_lo_q = b;
                        hunt_pos = PH_CRC_HI;
                    end
                    default: begin
                        // CRC high byte closes the frame with a summary.
                        item.kind      = KIND_SUMMARY;
                        item.direction = dir_q;
                        item.address   = addr_q;
                        item.length    = eff_len;
                        item.crc_ok    = ({b, crc_lo_q} == crc_q);
                        item.cmd_class = item.crc_ok ? address_class(addr_q) : CLS_CRC_ERROR;
                        item.last      = 1'b1;
                        frame_items_due.push_back(item);
                        in_body  = 1'b0;
                        hunt_pos = PH_DIR;
                    end
                endcase
            end
        end
        if (hunting) begin
            // Header hunt; a stray sync byte counts as the start of a new header.
            if (phase >= HDR_LEN) begin
                phase = PH_DIR;
            end
            if (b == SYNC_WORD[47 - 8 * phase -: 8]) begin
                phase = phase + 3'd1;
                if (phase == HDR_LEN) begin
                    in_body       = 1'b1;
                    hunt_pos      = PH_DIR;
                    payload_count = 8'd0;
                    crc_q         = CRC_INIT;
                end else begin
                    hunt_pos = phase;
                end
            end else begin
                hunt_pos = (b == SYNC_A) ? 3'd1 : 3'd0;
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_item(input t_frame_item want);
        t_out_data got;
        got = i_res_data;
        check_field("item_kind", want.kind, i_res_user);
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("data_index", want.data_index, got.data_index);
        check_field("direction", want.direction, got.direction);
        check_field("target_address", want.address, got.target_address);
        check_field("payload_length", want.length, got.payload_length);
        check_field("crc_ok", want.crc_ok, got.crc_ok);
        check_field("command_class", want.cmd_class, got.command_class);
        check_field("tdata padding", 0, got.pad);
        check_field("last", want.last, i_res_last);
    endtask

    // Both channels are sampled at the clock edge at which a request completes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hunt_pos      = PH_DIR;
            in_body       = 1'b0;
            payload_count = 8'd0;
            dir_q         = 8'd0;
            addr_q        = 16'd0;
            len_q         = 8'd0;
            crc_q         = CRC_INIT;
            crc_lo_q      = 8'd0;
        end else begin
            if (i_rx_valid && i_rx_ready) begin
                deframe_byte(i_rx_data);
            end
            if (i_res_valid && i_res_ready) begin
                if (frame_items_due.size() == 0) begin
                    $display({"%0t: unexpected result: expected none, ",
                              "actual tdata %h tuser %b tlast %b"},
                             $time, i_res_data, i_res_user, i_res_last);
                    mismatches++;
                end else begin
                    due_item = frame_items_due.pop_front();
                    compare_item(due_item);
                end
            end
        end
        o_pending    <= frame_items_due.size();
        o_fail_count <= mismatches;
    end

endmodule

[tb/testbench.sv]
// Top of the framed command receiver testbench: clock, reset, byte stimulus and verdict.
// Depends on fcr_pkg, framed_command_receiver_crc16_unit and framed_command_receiver_crc16_checker.
`timescale 1ns / 100ps

module testbench;
    import fcr_pkg::*;

    localparam logic [47:0] SYNC_WORD      = {SYNC_A, SYNC_B, SYNC_Z, SYNC_Z, SYNC_B, SYNC_A};
    localparam int          RANDOM_BYTES   = 1650;
    localparam int          QUIET_LIMIT    = 600;
    localparam int          TAIL_CYCLES    = 8;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        rx_valid  = 1'b0;
    logic [7:0]  rx_data   = 8'd0;
    logic        res_ready = 1'b0;
    logic        no_idle   = 1'b0;
    int          rx_stall  = 0;
    int          bytes_sent = 0;

    logic        rx_ready;
    logic        res_valid;
    logic [55:0] res_data;
    logic        res_user;
    logic        res_last;
    int          fail_count;
    int          pending;

    always #5 i_clk = ~i_clk;

    framed_command_receiver_crc16_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (rx_valid),
        .s_axis_tready (rx_ready),
        .s_axis_tdata  (rx_data),
        .m_axis_tvalid (res_valid),
        .m_axis_tready (res_ready),
        .m_axis_tdata  (res_data),
        .m_axis_tuser  (res_user),
        .m_axis_tlast  (res_last)
    );

    framed_command_receiver_crc16_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (rx_valid),
        .i_rx_ready   (rx_ready),
        .i_rx_data    (rx_data),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_data   (res_data),
        .i_res_user   (res_user),
        .i_res_last   (res_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: after a collected request, ready may drop for a random stall unless no_idle is set.
    always @(posedge i_clk) begin : result_pacing
        int stall;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
            rx_stall  <= 0;
        end else if (!res_ready) begin
            if (rx_stall <= 1) begin
                res_ready <= 1'b1;
            end
            rx_stall <= rx_stall - 1;
        end else if (res_valid) begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                res_ready <= 1'b0;
                rx_stall  <= stall;
            end
        end
    end

    // Ends the run when no request completes on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (rx_valid && rx_ready) || (res_valid && res_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("framed_command_receiver_crc16_unit verification failed");
        $finish;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    // Offers one byte after a random gap and returns at the edge where it is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_data  <= b;
        @(posedge i_clk);
        while (!rx_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_folded(input logic [7:0] b, inout logic [15:0] crc);
        crc = crc_step(crc, b);
        send_byte(b);
    endtask

    // Sends a complete frame; the payload length follows the direction rule of the block.
    task automatic send_frame(input logic [7:0] dir, input logic [15:0] addr,
                              input logic [7:0] len, input bit bad_crc);
        logic [15:0] crc;
        int          n;
        for (int i = 0; i < 6; i++) begin
            send_byte(SYNC_WORD[47 - 8 * i -: 8]);
        end
        crc = CRC_INIT;
        send_folded(dir, crc);
        send_folded(addr[7:0], crc);
        send_folded(addr[15:8], crc);
        send_folded(len, crc);
        n = (dir == DIR_WRITE) ? len : 0;
        repeat (n) send_folded(8'($urandom), crc);
        if (bad_crc) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    // Holds the sender back until every predicted result has been collected.
    task automatic drain_results();
        rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // A mostly well-formed frame with random fields, biased towards the class boundaries.
    task automatic send_random_frame();
        logic [7:0]  dir;
        logic [15:0] addr;
        logic [7:0]  len;
        int          pick;
        pick = $urandom_range(0, 9);
        dir = (pick < 7) ? DIR_WRITE : (pick == 7) ? 8'h00 : (pick == 8) ? 8'hFF : 8'($urandom);
        case ($urandom_range(0, 8))
            0:       addr = ADDR_ENTER;
            1:       addr = ADDR_ERASE;
            2:       addr = ADDR_VERIFY;
            3:       addr = ADDR_PROG_LO;
            4:       addr = ADDR_PROG_HI;
            5:       addr = 16'($urandom_range(ADDR_PROG_LO, ADDR_PROG_HI));
            6:       addr = ADDR_PROG_LO - 16'd1;
            7:       addr = ADDR_PROG_HI + 16'd1;
            default: addr = 16'($urandom);
        endcase
        pick = $urandom_range(0, 49);
        if (pick == 0) begin
            // Around the longest payload that still fits the body limit.
            len = 8'($urandom_range(216, 222));
        end else if (pick == 1) begin
            len = 8'($urandom_range(223, 255));
        end else if (pick < 10) begin
            len = 8'($urandom_range(9, 40));
        end else begin
            len = 8'($urandom_range(0, 8));
        end
        send_frame(dir, addr, len, $urandom_range(0, 6) == 0);
    endtask

    initial begin : stimulus
        int pick;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a stray sync byte before the header, a read frame whose length field is
        // ignored, then a write frame straight after it at the extreme address.
        send_byte(SYNC_A);
        send_frame(8'h00, ADDR_ENTER, 8'hFF, 1'b0);
        send_frame(DIR_WRITE, 16'hFFFF, 8'h01, 1'b0);
        drain_results();

        // Random frames, with noise, broken headers and truncated frames in between.
        while (bytes_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 4) == 0) begin
                no_idle <= ~no_idle;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_random_frame();
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 8)) begin
                    send_byte(($urandom_range(0, 3) == 0) ? SYNC_A : 8'($urandom));
                end
            end else if (pick < 90) begin
                for (int i = 0; i < $urandom_range(1, 5); i++) begin
                    send_byte(SYNC_WORD[47 - 8 * i -: 8]);
                end
                send_byte(($urandom_range(0, 1) == 0) ? SYNC_A : 8'($urandom));
            end else begin
                // Header and fields only; the following bytes run on as the body.
                for (int i = 0; i < 6; i++) begin
                    send_byte(SYNC_WORD[47 - 8 * i -: 8]);
                end
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
            if ($urandom_range(0, 24) == 0) begin
                drain_results();
            end
        end

        // Let every outstanding result arrive, then allow for the pipeline to settle.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("framed_command_receiver_crc16_unit verification clean");
        end else begin
            $display("framed_command_receiver_crc16_unit verification failed");
        end
        $finish;
    end

endmodule
